// ----- hw/rtl/pnp_pkg.sv -----
// ----------------------------------------------------------------------------
// pnp_pkg
// Types, character codes and digit helpers for the prefixed number parser.
// ----------------------------------------------------------------------------
package pnp_pkg;

   // Parse phase
   typedef enum logic [2:0] {
      PH_LEAD    = 3'd0,
      PH_ZERO    = 3'd1,
      PH_DIGITS  = 3'd2,
      PH_TRAIL   = 3'd3,
      PH_SWALLOW = 3'd4
   } phase_type;

   // Number base as reported in base_used
   typedef enum logic [1:0] {
      RAD_DEC = 2'd0,
      RAD_OCT = 2'd1,
      RAD_HEX = 2'd2
   } radix_type;

   // Result status
   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_MISSING = 2'd1,
      ST_ILLEGAL = 2'd2,
      ST_GARBAGE = 2'd3
   } status_type;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_LOW_X = 8'h78;
   localparam logic [7:0] CH_UP_X  = 8'h58;

   localparam logic [4:0] NO_DIGIT = 5'd16;

   localparam int CHAR_WIDTH = 8;
   localparam int RSP_WIDTH  = 40;   // value, status, base_used, bad_digit

   // Digit value 0..15, or NO_DIGIT for any other character
   function automatic logic [4:0] digit_value(input logic [7:0] c);
      logic [4:0] d;
      d = NO_DIGIT;
      if (c >= 8'h30 && c <= 8'h39) begin
         d = 5'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         d = 5'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         d = 5'(c - 8'h37);
      end
      return d;
   endfunction

   function automatic logic [4:0] radix_base(input radix_type r);
      logic [4:0] b;
      case (r)
         RAD_HEX: b = 5'd16;
         RAD_OCT: b = 5'd8;
         default: b = 5'd10;
      endcase
      return b;
   endfunction

endpackage

// ----- hw/rtl/prefixed_number_parser.sv -----
// ----------------------------------------------------------------------------
// prefixed_number_parser
// Character-stream parser for unsigned C-style literals (decimal, 0 octal,
// 0x hex) with leading/trailing blank skipping and error reporting.
// ----------------------------------------------------------------------------
//
//  channel | direction | tdata fields (lsb first)                  | bits
//  --------+-----------+-------------------------------------------+-----
//  req_    | in        | char_code[7:0]                            |  8
//  rsp_    | out       | value[31:0] status[33:32] base_used[35:34]|
//          |           | bad_digit[39:36]                          | 40
//
// One character per cycle sustained unless a terminator stalls. A character
// is held in the input register, then the parse state and (on NUL or LF)
// the result register are updated from it. Only a terminator can stall,
// and only while the result register still holds an untaken result;
// ordinary characters pass regardless. Reset (synchronous, active high)
// rearms the parser and empties both registers.
//
module prefixed_number_parser
   import pnp_pkg::*;
#(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [CHAR_WIDTH-1:0] req_tdata,    // char_code[7:0]

   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_WIDTH-1:0]  rsp_tdata     // value, status, base_used, bad_digit
);

   localparam int EXT_WIDTH = (VALUE_WIDTH > 32) ? VALUE_WIDTH : 32;

   // input register
   logic                  in_valid_ff, in_valid_in;
   logic [CHAR_WIDTH-1:0] in_char_ff;

   // parse state
   phase_type              phase_ff, phase_in;
   radix_type              radix_ff, radix_in;
   logic [VALUE_WIDTH-1:0] acc_ff, acc_in;
   status_type             err_ff, err_in;
   logic [3:0]             off_ff, off_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_WIDTH-1:0] rsp_data_ff, rsp_data_in;

   logic is_term;
   logic advance;

   assign is_term = (in_char_ff == CH_NUL) || (in_char_ff == CH_LF);

   // a terminator needs room in the result register; other characters never wait
   assign advance    = in_valid_ff && (!is_term || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_tvalid && req_tready) begin
         in_char_ff <= req_tdata;
      end
   end

   // next parse state and result
   always_comb begin
      logic                   blank;
      logic                   done;
      logic [4:0]             d;
      logic [4:0]             base;
      logic [VALUE_WIDTH-1:0] mac;
      logic [EXT_WIDTH-1:0]   acc_ext;
      logic [31:0]            value;
      status_type             status;
      radix_type              base_used;
      logic [3:0]             bad;

      phase_in = phase_ff;
      radix_in = radix_ff;
      acc_in   = acc_ff;
      err_in   = err_ff;
      off_in   = off_ff;
      done     = 1'b0;
      blank    = (in_char_ff == CH_SPACE) || (in_char_ff == CH_TAB);
      d        = digit_value(in_char_ff);

      // result fields for a terminator
      acc_ext   = EXT_WIDTH'(acc_ff);
      value     = 32'd0;
      status    = ST_OK;
      base_used = radix_ff;
      bad       = 4'd0;
      if (phase_ff == PH_LEAD) begin
         status    = ST_MISSING;
         base_used = RAD_DEC;
      end else if (phase_ff == PH_SWALLOW) begin
         status = err_ff;
         if (err_ff == ST_ILLEGAL) begin
            bad = off_ff;
         end
      end else begin
         value = acc_ext[31:0];
      end
      rsp_data_in = {bad, base_used, status, value};

      // prefix handling
      if (phase_ff == PH_LEAD) begin
         if (blank) begin
            done = 1'b1;
         end else if (in_char_ff == CH_ZERO) begin
            phase_in = PH_ZERO;
            done     = 1'b1;
         end else begin
            radix_in = RAD_DEC;
            phase_in = PH_DIGITS;
         end
      end else if (phase_ff == PH_ZERO) begin
         if (in_char_ff == CH_LOW_X || in_char_ff == CH_UP_X) begin
            radix_in = RAD_HEX;
            phase_in = PH_DIGITS;
            done     = 1'b1;
         end else begin
            radix_in = RAD_OCT;
            phase_in = PH_DIGITS;
         end
      end

      // acc * base + digit, base is 8, 10 or 16
      base = radix_base(radix_in);
      case (radix_in)
         RAD_HEX: mac = acc_ff << 4;
         RAD_OCT: mac = acc_ff << 3;
         default: mac = (acc_ff << 3) + (acc_ff << 1);
      endcase
      mac = mac + VALUE_WIDTH'(d[3:0]);

      if (!done && phase_in == PH_DIGITS) begin
         if (d != NO_DIGIT) begin
            if (d >= base) begin
               err_in   = ST_ILLEGAL;
               off_in   = d[3:0];
               phase_in = PH_SWALLOW;
            end else begin
               acc_in = mac;
            end
            done = 1'b1;
         end else begin
            phase_in = PH_TRAIL;
         end
      end

      if (!done && phase_in == PH_TRAIL && !blank) begin
         err_in   = ST_GARBAGE;
         phase_in = PH_SWALLOW;
      end

      // a terminator rearms the parser
      if (is_term) begin
         phase_in = PH_LEAD;
         radix_in = RAD_DEC;
         acc_in   = '0;
         err_in   = ST_OK;
         off_in   = 4'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LEAD;
         radix_ff <= RAD_DEC;
         acc_ff   <= '0;
         err_ff   <= ST_OK;
         off_ff   <= 4'd0;
      end else if (advance) begin
         phase_ff <= phase_in;
         radix_ff <= radix_in;
         acc_ff   <= acc_in;
         err_ff   <= err_in;
         off_ff   <= off_in;
      end
   end

   // result register: loads on a terminator, empties when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (advance && is_term) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (advance && is_term) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
